FILE: src/psted_pkg.sv
`timescale 1ns / 1ps

package psted_pkg;

	localparam int SLOTS    = 16;
	localparam int KEY_BITS = 16;

	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int PRIO_W  = 16;
	localparam int TIME_W  = 32;
	localparam int ENTRY_W = KEY_BITS + PRIO_W + TIME_W;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_CREATE = 2'd0;
	localparam cmd_t CMD_FREE   = 2'd1;
	localparam cmd_t CMD_QUERY  = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NULLKEY = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_BADHDL  = 2'd3;

endpackage

FILE: src/psted_ram.sv
`timescale 1ns / 1ps

module psted_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/priority_slot_table_with_expiry_unit.sv
`timescale 1ns / 1ps
// A query makes an expiry pass over all slots and then a pick pass, and a create with a nonzero
// key makes a search pass, a write step and then the pick pass; a free, a null-key create or the
// unused code skips the first pass and makes only the pick pass. Every command ends in a finish step.
// One command at a time; the next word can be accepted in the cycle in which the result appears.
// Reset clears all occupancy bits at once, so every slot is empty and no slot is active;
// the slot RAM itself is never cleared.
module priority_slot_table_with_expiry_unit
	import psted_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] entry_key,
	input  logic signed [15:0] entry_priority,
	input  logic [30:0] lifetime,
	input  logic [7:0]  slot_handle,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  created_slot,
	output logic        active_valid,
	output logic [3:0]  active_slot,
	output logic [15:0] active_key
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRITE, S_PICK, S_FINISH} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     v_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [SLOTS-1:0]         occ_q;

	cmd_t                     cmd_q;
	logic [KEY_BITS-1:0]      key_q;
	logic [PRIO_W-1:0]        prio_q;
	logic [30:0]              life_q;
	logic [TIME_W-1:0]        now_q;

	status_t                  status_q;
	logic                     found_q;
	logic [IDX_W-1:0]         at_q;
	logic signed [PRIO_W-1:0] best_q;
	logic                     best_valid_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [KEY_BITS-1:0]      best_key_q;

	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [3:0]               out_created_q;
	logic                     out_act_valid_q;
	logic [3:0]               out_act_slot_q;
	logic [15:0]              out_act_key_q;

	logic                     mem_we;
	logic [ENTRY_W-1:0]       mem_wdata;
	logic [IDX_W-1:0]         mem_raddr;
	logic [ENTRY_W-1:0]       mem_rdata;

	logic [KEY_BITS-1:0]      rd_key;
	logic [PRIO_W-1:0]        rd_prio;
	logic [TIME_W-1:0]        rd_dl;
	logic                     rd_occ;

	logic                     issuing;
	logic                     pass_done;
	logic [KEY_BITS-1:0]      in_key;
	logic                     accept;

	logic signed [TIME_W:0]   cmp_a;
	logic signed [TIME_W:0]   cmp_b;
	logic                     cmp_lt;

	logic [TIME_W:0]          dl_sum;
	logic [TIME_W-1:0]        dl_new;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign in_key    = KEY_BITS'(entry_key);

	assign issuing   = (cnt_q != CNT_W'(SLOTS));
	assign pass_done = !issuing && !v_s1;
	assign mem_raddr = cnt_q[IDX_W-1:0];

	assign rd_key  = mem_rdata[ENTRY_W-1 -: KEY_BITS];
	assign rd_prio = mem_rdata[TIME_W +: PRIO_W];
	assign rd_dl   = mem_rdata[TIME_W-1:0];
	assign rd_occ  = occ_q[idx_s1];

	// One signed compare serves both passes: deadline against now while
	// expiring, running best against the slot priority while picking.
	always_comb begin
		if (state_q == S_SCAN) begin
			cmp_a = $signed({1'b0, rd_dl});
			cmp_b = $signed({1'b0, now_q});
		end else begin
			cmp_a = (TIME_W+1)'(best_q);
			cmp_b = (TIME_W+1)'($signed(rd_prio));
		end
	end
	assign cmp_lt = (cmp_a < cmp_b);

	assign dl_sum = {1'b0, now_q} + {2'b00, life_q};
	always_comb begin
		if (life_q == '0) begin
			dl_new = '0;
		end else if (dl_sum[TIME_W]) begin
			dl_new = '1;
		end else begin
			dl_new = dl_sum[TIME_W-1:0];
		end
	end

	assign mem_we    = (state_q == S_WRITE) && found_q;
	assign mem_wdata = {key_q, prio_q, dl_new};

	psted_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(at_q),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cnt_q           <= '0;
			v_s1            <= 1'b0;
			idx_s1          <= '0;
			occ_q           <= '0;
			cmd_q           <= CMD_CREATE;
			key_q           <= '0;
			prio_q          <= '0;
			life_q          <= '0;
			now_q           <= '0;
			status_q        <= ST_OK;
			found_q         <= 1'b0;
			at_q            <= '0;
			best_q          <= '1;
			best_valid_q    <= 1'b0;
			best_idx_q      <= '0;
			best_key_q      <= '0;
			out_valid_q     <= 1'b0;
			out_status_q    <= ST_OK;
			out_created_q   <= '0;
			out_act_valid_q <= 1'b0;
			out_act_slot_q  <= '0;
			out_act_key_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if ((state_q == S_SCAN) || (state_q == S_PICK)) begin
				v_s1   <= issuing;
				idx_s1 <= cnt_q[IDX_W-1:0];
				if (issuing) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else begin
				v_s1 <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= command;
						key_q        <= in_key;
						prio_q       <= entry_priority;
						life_q       <= lifetime;
						now_q        <= now_time;
						cnt_q        <= '0;
						found_q      <= 1'b0;
						at_q         <= '0;
						best_q       <= '1;
						best_valid_q <= 1'b0;
						best_idx_q   <= '0;
						best_key_q   <= '0;
						status_q     <= ST_OK;
						case (command)
							CMD_CREATE: begin
								if (in_key == '0) begin
									status_q <= ST_NULLKEY;
									state_q  <= S_PICK;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_FREE: begin
								if ({1'b0, slot_handle} >= 9'(SLOTS)) begin
									status_q <= ST_BADHDL;
								end else begin
									occ_q[IDX_W'(slot_handle)] <= 1'b0;
								end
								state_q <= S_PICK;
							end
							CMD_QUERY: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_PICK;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (v_s1) begin
						if (cmd_q == CMD_CREATE) begin
							if (!found_q && (!rd_occ || (rd_key == key_q))) begin
								found_q <= 1'b1;
								at_q    <= idx_s1;
							end
						end else if (rd_occ && (rd_dl != '0) && cmp_lt) begin
							occ_q[idx_s1] <= 1'b0;
						end
					end
					if (pass_done) begin
						cnt_q   <= '0;
						state_q <= (cmd_q == CMD_CREATE) ? S_WRITE : S_PICK;
					end
				end
				S_WRITE: begin
					if (found_q) begin
						occ_q[at_q] <= 1'b1;
					end else begin
						status_q <= ST_FULL;
					end
					cnt_q   <= '0;
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (v_s1 && rd_occ && cmp_lt) begin
						best_q       <= $signed(rd_prio);
						best_valid_q <= 1'b1;
						best_idx_q   <= idx_s1;
						best_key_q   <= rd_key;
					end
					if (pass_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						out_status_q    <= status_q;
						out_created_q   <= found_q ? 4'(at_q) : 4'd0;
						out_act_valid_q <= best_valid_q;
						out_act_slot_q  <= 4'(best_idx_q);
						out_act_key_q   <= 16'(best_key_q);
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign created_slot = out_created_q;
	assign active_valid = out_act_valid_q;
	assign active_slot  = out_act_slot_q;
	assign active_key   = out_act_key_q;

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result appeared outside the finish step");

	a_read_pipe_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == S_SCAN || state_q == S_PICK))
		else $error("slot read pipeline active outside a scan pass");

	a_create_marks_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && found_q) |=> occ_q[$past(at_q)])
		else $error("created slot not marked occupied");

	a_pick_occ_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && $past(state_q == S_PICK)) |-> $stable(occ_q))
		else $error("occupancy changed during the pick pass");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import psted_pkg::*;

	// The command port also carries code 3, which the block treats as a no-op.
	localparam cmd_t CMD_SPARE   = 2'd3;
	localparam int   STALL_LIMIT = 2000;
	localparam int   DRAIN_CYCLES = 60;
	localparam int   RANDOM_WORDS = 1030;

	typedef struct packed {
		status_t     status;
		logic [3:0]  created_slot;
		logic        active_valid;
		logic [3:0]  active_slot;
		logic [15:0] active_key;
	} slot_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	cmd_t               command = CMD_QUERY;
	logic [15:0]        entry_key = '0;
	logic signed [15:0] entry_priority = '0;
	logic [30:0]        lifetime = '0;
	logic [7:0]         slot_handle = '0;
	logic [31:0]        now_time = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	status_t            status;
	logic [3:0]         created_slot;
	logic               active_valid;
	logic [3:0]         active_slot;
	logic [15:0]        active_key;

	// Shadow copy of the slot table.
	logic [15:0]        shadow_key[SLOTS];
	logic signed [15:0] shadow_prio[SLOTS];
	logic [31:0]        shadow_deadline[SLOTS];

	slot_result_t results_due[$];

	bit pace_random = 1'b0;
	int sink_hold = 0;
	int mismatches = 0;
	int n_create = 0, n_free = 0, n_query = 0, n_spare = 0;
	int n_nullkey = 0, n_full = 0, n_badhdl = 0, n_expired = 0;
	logic [31:0] wall_time = '0;

	priority_slot_table_with_expiry_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.entry_key(entry_key),
		.entry_priority(entry_priority),
		.lifetime(lifetime),
		.slot_handle(slot_handle),
		.now_time(now_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.created_slot(created_slot),
		.active_valid(active_valid),
		.active_slot(active_slot),
		.active_key(active_key)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic slot_result_t apply_command(cmd_t c, logic [15:0] k,
			logic signed [15:0] p, logic [30:0] life, logic [7:0] h, logic [31:0] now);
		slot_result_t r;
		int hit;
		int best;
		logic [32:0] sum;
		r = '0;
		hit = -1;
		best = -1;
		case (c)
			CMD_CREATE: begin
				if (k == '0) begin
					r.status = ST_NULLKEY;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (hit < 0 && (shadow_key[i] == '0 || shadow_key[i] == k))
							hit = i;
					if (hit < 0) begin
						r.status = ST_FULL;
					end else begin
						sum = {1'b0, now} + {2'b00, life};
						shadow_key[hit] = k;
						shadow_prio[hit] = p;
						if (life == '0)
							shadow_deadline[hit] = '0;
						else
							shadow_deadline[hit] = sum[32] ? '1 : sum[31:0];
						r.created_slot = hit[3:0];
					end
				end
			end
			CMD_FREE: begin
				if (h >= SLOTS)
					r.status = ST_BADHDL;
				else
					shadow_key[h] = '0;
			end
			CMD_QUERY: begin
				for (int i = 0; i < SLOTS; i++)
					if (shadow_key[i] != '0 && shadow_deadline[i] != '0 &&
							shadow_deadline[i] < now) begin
						shadow_key[i] = '0;
						n_expired++;
					end
			end
			default: begin
			end
		endcase
		// Lowest index wins a tie because only a strictly greater priority replaces it.
		for (int i = 0; i < SLOTS; i++)
			if (shadow_key[i] != '0 && int'(shadow_prio[i]) > best) begin
				best = int'(shadow_prio[i]);
				r.active_valid = 1'b1;
				r.active_slot = i[3:0];
				r.active_key = shadow_key[i];
			end
		return r;
	endfunction

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			shadow_key[i] = '0;
			shadow_prio[i] = '0;
			shadow_deadline[i] = '0;
		end
	end

	// Scoreboard: results are checked before the word accepted on the same edge is predicted.
	always @(posedge clk) begin
		slot_result_t seen, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = {status, created_slot, active_valid, active_slot, active_key};
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result with nothing pending: status=%0d created=%0d act=%0d/%0d/%h",
							seen.status, seen.created_slot, seen.active_valid,
							seen.active_slot, seen.active_key);
				end else begin
					want = results_due.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch at %0t: status %0d/%0d created %0d/%0d valid %0d/%0d slot %0d/%0d key %h/%h (expected/actual)",
								$realtime, want.status, seen.status, want.created_slot,
								seen.created_slot, want.active_valid, seen.active_valid,
								want.active_slot, seen.active_slot, want.active_key,
								seen.active_key);
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_command(command, entry_key, entry_priority, lifetime,
					slot_handle, now_time);
				results_due.push_back(want);
				case (command)
					CMD_CREATE: n_create++;
					CMD_FREE: n_free++;
					CMD_QUERY: n_query++;
					default: n_spare++;
				endcase
				case (want.status)
					ST_NULLKEY: n_nullkey++;
					ST_FULL: n_full++;
					ST_BADHDL: n_badhdl++;
					default: begin
					end
				endcase
			end
		end
	end

	// Result side: random stall before each word, plus an occasional long hold.
	initial begin : result_sink
		int wait_cycles;
		forever begin
			if (sink_hold > 0) begin
				out_stall <= 1'b1;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			wait_cycles = pace_random ? $urandom_range(0, 12) : 0;
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	task automatic send_command(input cmd_t c, input logic [15:0] k,
			input logic signed [15:0] p, input logic [30:0] life, input logic [7:0] h,
			input logic [31:0] now);
		int gap;
		gap = pace_random ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		entry_key <= k;
		entry_priority <= p;
		lifetime <= life;
		slot_handle <= h;
		now_time <= now;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_create(input logic [15:0] k, input logic signed [15:0] p,
			input logic [30:0] life, input logic [31:0] now);
		send_command(CMD_CREATE, k, p, life, 8'($urandom), now);
	endtask

	task automatic send_free(input logic [7:0] h);
		send_command(CMD_FREE, 16'($urandom), 16'($urandom), 31'($urandom), h, $urandom);
	endtask

	task automatic send_query(input logic [31:0] now);
		send_command(CMD_QUERY, 16'($urandom), 16'($urandom), 31'($urandom),
			8'($urandom), now);
	endtask

	task automatic test_directed();
		pace_random = 1'b0;
		send_query(32'd0);
		send_create(16'h0000, 16'sd5, 31'd10, 32'd0);
		// Deadline saturates past the top of the time range.
		send_create(16'hFFFF, 16'sh7FFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_create(16'h0001, 16'sh8000, 31'd0, 32'd0);
		send_create(16'h0002, -16'sd1, 31'd1, 32'd100);
		send_create(16'h0003, 16'sd0, 31'd5, 32'd100);
		send_create(16'h0004, 16'sd0, 31'h7FFF_FFFF, 32'h8000_0000);
		// Same key again overwrites slot zero and drops its priority to a tie.
		send_create(16'hFFFF, 16'sd0, 31'd0, 32'd50);
		send_query(32'd101);
		send_query(32'd102);
		send_query(32'd106);
		send_query(32'hFFFF_FFFF);
		send_command(CMD_SPARE, 16'h1234, 16'sd9, 31'd3, 8'd2, 32'd7);
		send_free(8'd0);
		send_free(8'd0);
		send_free(8'd16);
		send_free(8'd255);
		send_free(8'd4);
		send_free(8'd1);
	endtask

	task automatic test_full_table();
		pace_random = 1'b1;
		for (int i = 0; i < SLOTS; i++)
			send_create(16'h0100 + 16'(i), 16'($urandom_range(0, 6)), 31'd0, 32'd0);
		send_create(16'h0200, 16'sd3, 31'd0, 32'd0);
		send_create(16'h0105, 16'sd40, 31'd0, 32'd0);
		send_free(8'd7);
		send_create(16'h0200, 16'sd40, 31'd0, 32'd0);
		for (int i = 0; i < SLOTS; i++)
			send_free(8'(i));
	endtask

	task automatic test_random_traffic(input int count);
		int pick;
		logic [15:0] k;
		logic signed [15:0] p;
		logic [30:0] life;
		logic [7:0] h;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0)
				pace_random = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 49) == 0)
				wall_time = $urandom;
			else
				wall_time = wall_time + $urandom_range(0, 20);
			// A small key pool keeps the table busy with matches and full conditions.
			pick = $urandom_range(0, 19);
			if (pick == 0)
				k = '0;
			else if (pick <= 2)
				k = 16'($urandom);
			else
				k = 16'($urandom_range(1, 20));
			if ($urandom_range(0, 9) < 2)
				p = 16'($urandom);
			else
				p = 16'($urandom_range(0, 20)) - 16'sd3;
			pick = $urandom_range(0, 19);
			if (pick < 5)
				life = '0;
			else if (pick < 15)
				life = 31'($urandom_range(1, 60));
			else if (pick < 18)
				life = 31'($urandom);
			else
				life = 31'h7FFF_FFFF;
			if ($urandom_range(0, 99) < 85)
				h = 8'($urandom_range(0, SLOTS - 1));
			else
				h = 8'($urandom_range(SLOTS, 255));
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_command(CMD_CREATE, k, p, life, h, wall_time);
			else if (pick < 70)
				send_command(CMD_FREE, k, p, life, h, wall_time);
			else if (pick < 95)
				send_command(CMD_QUERY, k, p, life, h, wall_time);
			else
				send_command(CMD_SPARE, k, p, life, h, wall_time);
		end
	endtask

	// The result side holds off while words keep coming, so the block backs up.
	task automatic test_backpressure();
		pace_random = 1'b0;
		sink_hold = 300;
		for (int n = 0; n < 20; n++) begin
			wall_time = wall_time + $urandom_range(0, 5);
			send_command(cmd_t'($urandom_range(0, 2)), 16'($urandom_range(1, 20)),
				16'($urandom), 31'($urandom_range(0, 30)), 8'($urandom_range(0, 17)),
				wall_time);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random_traffic(RANDOM_WORDS);
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d commands: %0d creates, %0d frees, %0d queries, %0d spare codes.",
			n_create + n_free + n_query + n_spare, n_create, n_free, n_query, n_spare);
		$display("Saw %0d null keys, %0d full tables, %0d bad handles, %0d expiries; %0d mismatches.",
			n_nullkey, n_full, n_badhdl, n_expired, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
